// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define DOPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define DOPS_NEVER(label, cond, msg) \
  `DOPS_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/dops_pkg.sv =====
// types and constants of the open-page command sequencer
package dops_pkg;

  localparam int BANK_COUNT = 32;
  localparam int BANK_W     = 5;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int WAIT_W     = 11;

  // operation code for a write; every other code reads
  localparam logic [1:0] OP_WRITE = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TO_COL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LAT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_REC   = 3'd5;

  typedef enum logic [2:0] {
    CMD_PRE  = 3'd0,
    CMD_ACT0 = 3'd1,
    CMD_ACT1 = 3'd2,
    CMD_RD0  = 3'd3,
    CMD_RD1  = 3'd4,
    CMD_WR0  = 3'd5,
    CMD_WR1  = 3'd6
  } cmd_e_t;

  // bank state class of a request
  typedef enum logic [1:0] {
    KIND_HIT    = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_MISS   = 2'd2
  } kind_t;

  // command step of the back end sequencer
  typedef enum logic [4:0] {
    ST_PRE  = 5'b00001,
    ST_ACT0 = 5'b00010,
    ST_ACT1 = 5'b00100,
    ST_CAS0 = 5'b01000,
    ST_CAS1 = 5'b10000
  } step_t;

  typedef struct packed {
    logic [1:0]  op_code;
    logic [33:0] address;
  } in_item_t;

  typedef struct packed {
    cmd_e_t            command;
    logic              channel;
    logic [2:0]        bank_group;
    logic [BANK_W-1:0] bank_number;
    logic [15:0]       row_or_column;
    logic [WAIT_W-1:0] wait_after;
    logic              last_command;
  } out_item_t;

  // classified request as held in the queue
  typedef struct packed {
    kind_t             kind;
    logic              is_write;
    logic              channel;
    logic [2:0]        bank_group;
    logic [BANK_W-1:0] bank_number;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } req_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] row_to_col_delay;
    logic [CFG_DATA_W-1:0] precharge_delay;
    logic [CFG_DATA_W-1:0] read_latency;
    logic [CFG_DATA_W-1:0] write_latency;
    logic [CFG_DATA_W-1:0] burst_time;
    logic [CFG_DATA_W-1:0] write_recovery;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/dops_front.sv =====
// front end: address decode, bank state lookup and request classification
module dops_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dops_pkg::in_item_t in_data,
  input  dops_pkg::q_stat_t q_stat,
  output logic              push,
  output dops_pkg::req_t    push_data
);

  logic [dops_pkg::BANK_COUNT-1:0] bank_open_r;
  logic [dops_pkg::ROW_W-1:0]      bank_row_r [dops_pkg::BANK_COUNT];

  logic [dops_pkg::BANK_W-1:0] bnum;
  logic [dops_pkg::ROW_W-1:0]  row;
  logic                        accept;

  // fixed address map
  assign row  = in_data.address[33:18];
  assign bnum = {in_data.address[9:7], in_data.address[11:10]};

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  // classify against the bank state
  always_comb begin
    push_data.is_write    = (in_data.op_code == dops_pkg::OP_WRITE);
    push_data.channel     = in_data.address[6];
    push_data.bank_group  = in_data.address[9:7];
    push_data.bank_number = bnum;
    push_data.row         = row;
    push_data.col         = {in_data.address[17:12], in_data.address[5:2]};
    if (!bank_open_r[bnum]) begin
      push_data.kind = dops_pkg::KIND_CLOSED;
    end else if (bank_row_r[bnum] == row) begin
      push_data.kind = dops_pkg::KIND_HIT;
    end else begin
      push_data.kind = dops_pkg::KIND_MISS;
    end
  end

  // open flags, all banks closed after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_open_r <= '0;
    end else if (accept) begin
      bank_open_r[bnum] <= 1'b1;
    end
  end

  // open row per bank, only read while the bank is open
  always_ff @(posedge clk) begin
    if (accept) begin
      bank_row_r[bnum] <= row;
    end
  end

endmodule

// ===== rtl/dops_queue.sv =====
// request queue between the front end and the command sequencer
module dops_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dops_pkg::req_t    push_data,
  input  logic              pop,
  output dops_pkg::req_t    head,
  output dops_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dops_pkg::req_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  // pointers wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/dops_back.sv =====
// back end: steps through the command sequence of the head request
module dops_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dops_pkg::q_stat_t   q_stat,
  input  dops_pkg::req_t      head,
  input  dops_pkg::cfg_t      cfg,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output dops_pkg::out_item_t out_data
);

  dops_pkg::step_t     step_r, step_nxt, cur_step, first_step;
  logic                fresh_r, fresh_nxt;
  logic                issue;
  logic                out_valid_r, out_valid_nxt;
  dops_pkg::out_item_t out_data_r, cmd_beat;
  logic [9:0]          wr_sum;
  logic [8:0]          rd_sum;

  // first step follows the bank state class
  always_comb begin
    unique case (head.kind)
      dops_pkg::KIND_MISS:   first_step = dops_pkg::ST_PRE;
      dops_pkg::KIND_CLOSED: first_step = dops_pkg::ST_ACT0;
      default:               first_step = dops_pkg::ST_CAS0;
    endcase
  end

  assign cur_step = fresh_r ? first_step : step_r;
  assign issue    = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop      = issue && (cur_step == dops_pkg::ST_CAS1);

  assign wr_sum = 10'(cfg.write_latency) + 10'(cfg.burst_time) + 10'(cfg.write_recovery);
  assign rd_sum = 9'(cfg.read_latency) + 9'(cfg.burst_time);

  // command beat for the current step
  always_comb begin
    cmd_beat.channel      = head.channel;
    cmd_beat.bank_group   = head.bank_group;
    cmd_beat.bank_number  = head.bank_number;
    cmd_beat.last_command = (cur_step == dops_pkg::ST_CAS1);
    step_nxt              = step_r;
    unique case (cur_step)
      dops_pkg::ST_PRE: begin
        cmd_beat.command       = dops_pkg::CMD_PRE;
        cmd_beat.row_or_column = '0;
        cmd_beat.wait_after    = {2'b00, cfg.precharge_delay, 1'b0};
        step_nxt               = dops_pkg::ST_ACT0;
      end
      dops_pkg::ST_ACT0: begin
        cmd_beat.command       = dops_pkg::CMD_ACT0;
        cmd_beat.row_or_column = head.row;
        cmd_beat.wait_after    = 11'd2;
        step_nxt               = dops_pkg::ST_ACT1;
      end
      dops_pkg::ST_ACT1: begin
        cmd_beat.command       = dops_pkg::CMD_ACT1;
        cmd_beat.row_or_column = head.row;
        cmd_beat.wait_after    = {2'b00, cfg.row_to_col_delay, 1'b0};
        step_nxt               = dops_pkg::ST_CAS0;
      end
      dops_pkg::ST_CAS0: begin
        cmd_beat.command       = head.is_write ? dops_pkg::CMD_WR0 : dops_pkg::CMD_RD0;
        cmd_beat.row_or_column = {6'b0, head.col};
        cmd_beat.wait_after    = 11'd2;
        step_nxt               = dops_pkg::ST_CAS1;
      end
      dops_pkg::ST_CAS1: begin
        cmd_beat.command       = head.is_write ? dops_pkg::CMD_WR1 : dops_pkg::CMD_RD1;
        cmd_beat.row_or_column = {6'b0, head.col};
        cmd_beat.wait_after    = head.is_write ? {wr_sum, 1'b0} : {1'b0, rd_sum, 1'b0};
        step_nxt               = dops_pkg::ST_PRE;
      end
      default: begin
        cmd_beat.command       = dops_pkg::CMD_PRE;
        cmd_beat.row_or_column = '0;
        cmd_beat.wait_after    = '0;
        step_nxt               = dops_pkg::ST_PRE;
      end
    endcase
  end

  // sequencer state
  always_comb begin
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r;
    if (issue) begin
      fresh_nxt     = pop;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= dops_pkg::ST_PRE;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        step_r <= step_nxt;
      end
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (issue) begin
      out_data_r <= cmd_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/dram_open_page_command_sequencer_unit.sv =====
// top level of the open-page command sequencer: config registers and wiring
// request path: the queue entry, then the command output register
// throughput: one command beat per cycle unless out_ready stalls; a request
// takes 2 (row hit), 4 (closed bank) or 5 (row miss) command beats
// reset: synchronous; all banks closed, queue empty, timing registers to defaults
module dram_open_page_command_sequencer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dops_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dops_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [dops_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dops_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

`include "assert_macros.svh"

  dops_pkg::cfg_t    cfg_r, cfg_nxt;
  dops_pkg::q_stat_t q_stat;
  dops_pkg::req_t    push_data, head;
  logic              push, pop;
  logic              out_cas1;
  logic              last_bad;
  logic              pre_row_bad;
  logic              act0_taken;
  logic              act1_shown;

  // timing register writes, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dops_pkg::CFG_ROW_TO_COL: cfg_nxt.row_to_col_delay = cfg_wdata;
        dops_pkg::CFG_PRECHARGE:  cfg_nxt.precharge_delay  = cfg_wdata;
        dops_pkg::CFG_READ_LAT:   cfg_nxt.read_latency     = cfg_wdata;
        dops_pkg::CFG_WRITE_LAT:  cfg_nxt.write_latency    = cfg_wdata;
        dops_pkg::CFG_BURST:      cfg_nxt.burst_time       = cfg_wdata;
        dops_pkg::CFG_WRITE_REC:  cfg_nxt.write_recovery   = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_to_col_delay <= 8'd39;
      cfg_r.precharge_delay  <= 8'd39;
      cfg_r.read_latency     <= 8'd40;
      cfg_r.write_latency    <= 8'd38;
      cfg_r.burst_time       <= 8'd8;
      cfg_r.write_recovery   <= 8'd72;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // request decode and classification
  dops_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // classified request queue
  dops_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // command sequencer
  dops_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .cfg       (cfg_r),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // terms for the checks
  assign out_cas1    = (out_data.command == dops_pkg::CMD_RD1) ||
                       (out_data.command == dops_pkg::CMD_WR1);
  assign last_bad    = out_valid && (out_data.last_command != out_cas1);
  assign pre_row_bad = out_valid && (out_data.command == dops_pkg::CMD_PRE) &&
                       (out_data.row_or_column != '0);
  assign act0_taken  = out_valid && out_ready && (out_data.command == dops_pkg::CMD_ACT0);
  assign act1_shown  = out_valid && (out_data.command == dops_pkg::CMD_ACT1);

  // checks
  `DOPS_NEVER(a_last_on_cas1, last_bad, "last flag not on final column command")
  `DOPS_NEVER(a_pre_row_zero, pre_row_bad, "precharge with nonzero row field")
  `DOPS_ASSERT(a_act1_follows, act0_taken |=> act1_shown, "activate second half missing")

endmodule
